[design/igc_pkg.sv]
// ----------------------------------------------------------------------------
// igc_pkg: shared types and constants of the iteration gradient colorizer
// Widths of the count, position and colour fields, the palette table and
// the pipeline control types.
// ----------------------------------------------------------------------------
package igc_pkg;

   localparam int CNT_W               = 16;
   localparam int CHAN_W              = 8;
   localparam int COLOR_W             = 3 * CHAN_W;
   localparam int PALETTE_ENTRIES     = 16;
   localparam int IDX_W               = $clog2(PALETTE_ENTRIES);
   localparam int FRACTION_BITS_DFLT  = 8;
   localparam logic [CNT_W-1:0] MAX_COUNT_RESET = 16'd256;

   // red 23:16, green 15:8, blue 7:0
   localparam logic [COLOR_W-1:0] PALETTE_TABLE [PALETTE_ENTRIES] = '{
      24'h421E0F, 24'h19071A, 24'h09012F, 24'h040449,
      24'h000764, 24'h0C2C8A, 24'h1852B1, 24'h397DD1,
      24'h86B5E5, 24'hD3ECF8, 24'hF1E9BF, 24'hF8C95F,
      24'hFFAA00, 24'hCC8000, 24'h995700, 24'h6A3403
   };

   typedef struct packed {
      logic advance_a;
      logic advance_b;
   } blend_ctrl_type;

endpackage

[design/igc_div_stage.sv]
// ----------------------------------------------------------------------------
// igc_div_stage: one restoring division step
// Decides one quotient bit by a compare and subtract of the shifted divisor
// and registers the partial remainder and quotient.
// ----------------------------------------------------------------------------
module igc_div_stage #(
   parameter int NUM_W = 28,
   parameter int Q_W   = 12,
   parameter int BIT   = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic [igc_pkg::CNT_W-1:0]    divisor,
   input  logic                         in_valid,
   input  logic [NUM_W-1:0]             in_rem,
   input  logic [Q_W-1:0]               in_quot,
   output logic                         out_valid,
   output logic [NUM_W-1:0]             out_rem,
   output logic [Q_W-1:0]               out_quot
);

   logic             valid_ff;
   logic [NUM_W-1:0] rem_ff, rem_in;
   logic [Q_W-1:0]   quot_ff, quot_in;
   logic [NUM_W-1:0] shifted;
   logic             take;

   always_comb begin
      shifted = NUM_W'(divisor) << BIT;
      take    = (in_rem >= shifted);
      rem_in  = take ? (in_rem - shifted) : in_rem;
      quot_in = {in_quot[Q_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_quot  = quot_ff;

endmodule

[design/igc_blend.sv]
// ----------------------------------------------------------------------------
// igc_blend: palette lookup and linear blend
// First stage looks up both palette entries and forms the scaled channel
// differences; second stage rounds toward zero, adds, clamps and packs the colour.
// ----------------------------------------------------------------------------
module igc_blend #(
   parameter int FRACTION_BITS = igc_pkg::FRACTION_BITS_DFLT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  igc_pkg::blend_ctrl_type                  ctrl,
   input  logic                                     in_valid,
   input  logic [igc_pkg::IDX_W+FRACTION_BITS-1:0]  in_pos,
   output logic                                     valid_a,
   output logic                                     valid_b,
   output logic [igc_pkg::COLOR_W-1:0]              rgb
);

   localparam int CW  = igc_pkg::CHAN_W;
   localparam int P_W = CW + 2 + FRACTION_BITS;
   localparam logic [igc_pkg::IDX_W-1:0] LAST_IDX =
      igc_pkg::IDX_W'(igc_pkg::PALETTE_ENTRIES - 1);

   logic [igc_pkg::IDX_W-1:0]  idx, nxt;
   logic [FRACTION_BITS-1:0]   frac;
   logic [igc_pkg::COLOR_W-1:0] col_a, col_b;

   logic                   va_ff, vb_ff;
   logic [CW-1:0]          start_ff [3];
   logic [CW-1:0]          start_in [3];
   logic signed [P_W-1:0]  prod_ff [3];
   logic signed [P_W-1:0]  prod_in [3];
   logic [igc_pkg::COLOR_W-1:0] rgb_ff, rgb_in;

   logic signed [CW:0]     diff;
   logic signed [P_W-1:0]  biased, step;
   logic signed [CW+2:0]   val;

   always_comb begin
      idx   = in_pos[igc_pkg::IDX_W+FRACTION_BITS-1:FRACTION_BITS];
      frac  = in_pos[FRACTION_BITS-1:0];
      nxt   = (idx == LAST_IDX) ? idx : idx + igc_pkg::IDX_W'(1);
      col_a = igc_pkg::PALETTE_TABLE[idx];
      col_b = igc_pkg::PALETTE_TABLE[nxt];
      diff  = '0;
      for (int c = 0; c < 3; c++) begin
         start_in[c] = col_a[(2-c)*CW +: CW];
         diff        = $signed({1'b0, col_b[(2-c)*CW +: CW]}) - $signed({1'b0, start_in[c]});
         prod_in[c]  = P_W'(diff) * P_W'($signed({1'b0, frac}));
      end
   end

   // truncate the scaled step toward zero, then add to the start colour
   always_comb begin
      rgb_in = '0;
      biased = '0;
      step   = '0;
      val    = '0;
      for (int c = 0; c < 3; c++) begin
         biased = prod_ff[c] + (prod_ff[c][P_W-1] ?
                  P_W'((1 << FRACTION_BITS) - 1) : P_W'(0));
         step   = biased >>> FRACTION_BITS;
         val    = (CW+3)'(step) + (CW+3)'($signed({1'b0, start_ff[c]}));
         if (val < 0) begin
            rgb_in[(2-c)*CW +: CW] = '0;
         end else if (val > $signed((CW+3)'(255))) begin
            rgb_in[(2-c)*CW +: CW] = '1;
         end else begin
            rgb_in[(2-c)*CW +: CW] = val[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         if (ctrl.advance_a) begin
            va_ff <= in_valid;
         end
         if (ctrl.advance_b) begin
            vb_ff <= va_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance_a) begin
         start_ff <= start_in;
         prod_ff  <= prod_in;
      end
      if (ctrl.advance_b) begin
         rgb_ff <= rgb_in;
      end
   end

   assign valid_a = va_ff;
   assign valid_b = vb_ff;
   assign rgb     = rgb_ff;

endmodule

[design/iteration_gradient_colorizer_top.sv]
// ----------------------------------------------------------------------------
// iteration_gradient_colorizer_top: escape-time count to RGB colour
// Pipelined position divider followed by a palette blend.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel: one iteration count per beat, taken when req_valid is
//    high and req_stall is low.
//  - rsp_ channel: one packed colour per beat (red 23:16, green 15:8,
//    blue 7:0), taken when rsp_valid is high and rsp_stall is low.
//  - csr_ channel: writes max_count; csr_ready is always high. A value of
//    zero is stored as one. Write only while the pipeline is empty.
//  - Throughput: one beat per cycle while rsp_stall is low. The restoring
//    divider spends one registered stage on each quotient bit of the
//    position.
//  - Stall: each stage moves when it is empty or the next stage moves, so
//    bubbles close up under a stalled receiver; req_stall rises only once
//    every stage holds a beat.
//  - Reset: synchronous; clears every valid bit and sets max_count to 256.
// ----------------------------------------------------------------------------
module iteration_gradient_colorizer_top #(
   parameter int FRACTION_BITS = igc_pkg::FRACTION_BITS_DFLT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [igc_pkg::CNT_W-1:0]     req_iteration_count,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [igc_pkg::COLOR_W-1:0]   rsp_rgb_color,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [igc_pkg::CNT_W-1:0]     csr_max_count
);

   localparam int Q_W    = igc_pkg::IDX_W + FRACTION_BITS;
   localparam int NUM_W  = igc_pkg::CNT_W + igc_pkg::IDX_W + FRACTION_BITS;
   localparam int STAGES = Q_W + 3;

   logic [igc_pkg::CNT_W-1:0] maxc_ff, maxc_in;
   logic [igc_pkg::CNT_W-1:0] cnt_sat;

   logic [STAGES-1:0] adv;
   logic [STAGES-1:0] vld;

   logic             front_valid_ff;
   logic [NUM_W-1:0] num_ff, num_in;

   logic [NUM_W-1:0] rem_pipe  [Q_W+1];
   logic [Q_W-1:0]   quot_pipe [Q_W+1];
   logic [Q_W:0]     vld_pipe;

   igc_pkg::blend_ctrl_type blend_ctrl;
   logic                    blend_va, blend_vb;

   // ---- configuration ----
   assign csr_ready = 1'b1;
   assign maxc_in   = (csr_max_count == '0) ? igc_pkg::CNT_W'(1) : csr_max_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         maxc_ff <= igc_pkg::MAX_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         maxc_ff <= maxc_in;
      end
   end

   // ---- flow control: advance a stage when empty or when the next advances ----
   always_comb begin
      adv[STAGES-1] = !vld[STAGES-1] || !rsp_stall;
      for (int k = STAGES - 2; k >= 0; k--) begin
         adv[k] = !vld[k] || adv[k+1];
      end
   end

   assign req_stall = !adv[0];

   // ---- front stage: saturate and scale the count ----
   always_comb begin
      cnt_sat = (req_iteration_count > maxc_ff) ? maxc_ff : req_iteration_count;
      num_in  = (NUM_W'(cnt_sat) * NUM_W'(igc_pkg::PALETTE_ENTRIES - 1)) << FRACTION_BITS;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else if (adv[0]) begin
         front_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         num_ff <= num_in;
      end
   end

   assign vld[0]       = front_valid_ff;
   assign vld_pipe[0]  = front_valid_ff;
   assign rem_pipe[0]  = num_ff;
   assign quot_pipe[0] = '0;

   // ---- divider: one quotient bit per stage, most significant first ----
   for (genvar i = 0; i < Q_W; i++) begin : g_div
      igc_div_stage #(
         .NUM_W (NUM_W),
         .Q_W   (Q_W),
         .BIT   (Q_W - 1 - i)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (adv[i+1]),
         .divisor   (maxc_ff),
         .in_valid  (vld_pipe[i]),
         .in_rem    (rem_pipe[i]),
         .in_quot   (quot_pipe[i]),
         .out_valid (vld_pipe[i+1]),
         .out_rem   (rem_pipe[i+1]),
         .out_quot  (quot_pipe[i+1])
      );
      assign vld[i+1] = vld_pipe[i+1];
   end

   // ---- palette blend ----
   assign blend_ctrl.advance_a = adv[Q_W+1];
   assign blend_ctrl.advance_b = adv[Q_W+2];

   igc_blend #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_blend (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (blend_ctrl),
      .in_valid (vld_pipe[Q_W]),
      .in_pos   (quot_pipe[Q_W]),
      .valid_a  (blend_va),
      .valid_b  (blend_vb),
      .rgb      (rsp_rgb_color)
   );

   assign vld[Q_W+1] = blend_va;
   assign vld[Q_W+2] = blend_vb;
   assign rsp_valid  = blend_vb;

endmodule

[design/igc_checker.sv]
// ----------------------------------------------------------------------------
// igc_checker: port-level checks of the colorizer
// Watches the request, response and register ports of the top level.
// ----------------------------------------------------------------------------
module igc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic [igc_pkg::CNT_W-1:0]     req_iteration_count,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [igc_pkg::COLOR_W-1:0]   rsp_rgb_color,
   input logic                          csr_valid,
   input logic                          csr_ready
);

   // a stalled result beat stays and holds its colour
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_rgb_color))
      else $error("stalled result beat changed or dropped");

   // a stalled request beat stays and holds its count
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_iteration_count))
      else $error("stalled request beat changed or dropped");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat present after reset");

   // the input backs up only when the output is full and stalled
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || !rsp_stall) |-> !req_stall)
      else $error("request stalled while the result side moves");

   // register writes are never refused
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write refused");

endmodule

bind iteration_gradient_colorizer_top igc_checker u_igc_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .req_iteration_count (req_iteration_count),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_rgb_color       (rsp_rgb_color),
   .csr_valid           (csr_valid),
   .csr_ready           (csr_ready)
);
